@@ design/mwcs_pkg.sv @@
// Shared types and constants of the Mann-Whitney change-point scan.
package mwcs_pkg;

	// Field and register widths
	localparam int RANK_W    = 13;
	localparam int CFG_W     = 13;
	localparam int REG_IDX_W = 4;
	localparam int SUM_W     = 24;
	localparam int IDX_W     = 12;
	localparam int STAT_W    = 24;

	// Datapath widths (worst case over 13-bit registers)
	localparam int N_W    = 13;  // n0, n1
	localparam int TC1_W  = 14;  // total_count + 1
	localparam int MUL_W  = 27;  // multiplier operand
	localparam int PROD_W = 54;  // multiplier product
	localparam int D_W    = 28;  // signed D = 2*R1 - n0*(tc+1)
	localparam int M_W    = 58;  // 12 * D^2
	localparam int V_W    = 40;  // n0 * n1 * (tc+1)
	localparam int QUO_W  = 48;  // saturated quotient 12*D^2*2^32 / V
	localparam int ROOT_W = 24;  // integer root of the quotient
	localparam int DSH_W  = 16;  // dividend bits shifted in during division
	localparam int SUB_W  = 41;  // shared subtractor width
	localparam int SQR_W  = 26;  // root remainder width
	localparam int CNT_W  = 6;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_SERIES_LENGTH = 4'd0;
	localparam logic [REG_IDX_W-1:0] REG_TOTAL_COUNT   = 4'd1;

	// Reset value of both registers
	localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

	// Saturation limits of the statistic
	localparam logic [STAT_W-1:0] SAT_POS  = 24'h7FFFFF;
	localparam logic [ROOT_W-1:0] MAG_CAP  = 24'h800000;

	// Top-level sequencer states
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL1  = 8'b0000_0010,
		ST_MUL2  = 8'b0000_0100,
		ST_MUL3  = 8'b0000_1000,
		ST_MUL4  = 8'b0001_0000,
		ST_SETUP = 8'b0010_0000,
		ST_ROOT  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} mwcs_state_t;

	// Divide/root unit phases
	typedef enum logic [2:0] {
		DS_IDLE = 3'b001,
		DS_DIV  = 3'b010,
		DS_ROOT = 3'b100
	} mwcs_ds_phase_t;

	// Request into the divide/root unit
	typedef struct packed {
		logic               start;
		logic [DSH_W-1:0]   num_lo;
		logic [V_W-1:0]     rem_init;
		logic [V_W-1:0]     den;
	} mwcs_ds_req_t;

	// Status out of the divide/root unit
	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} mwcs_ds_rsp_t;

endpackage

@@ design/mann_whitney_changepoint_scan.sv @@
// Mann-Whitney change-point scan: rank sum, split statistic (U-mu)/sd per item.
// Steps: accept only when no split is reported; accept and output load for a split with
// an empty second group; else accept, 4 multiplier passes, setup, then if not saturated
// a 48-bit divide and a 24-bit root on the shared subtractor, then the output load.
// The output register lets the next transaction enter while a result waits; a second
// result holds the load until the first is taken. Reset (arst_n low) clears rank sum,
// position and valids; both registers go to 4096.
module mann_whitney_changepoint_scan #(
	parameter int MAX_LEN = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mwcs_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [mwcs_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [mwcs_pkg::RANK_W-1:0]        rank,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [mwcs_pkg::IDX_W-1:0]         split_index,
	output logic signed [mwcs_pkg::STAT_W-1:0] statistic,
	output logic                               invalid
);

	// Series length never exceeds what a 13-bit register holds
	localparam int LEN_CAP_I = (MAX_LEN > 8191) ? 8191 : MAX_LEN;
	localparam int POS_W     = $clog2(LEN_CAP_I);
	localparam logic [mwcs_pkg::CFG_W-1:0] LEN_CAP = 13'(LEN_CAP_I);

	mwcs_pkg::mwcs_state_t              state_q;
	logic [mwcs_pkg::CFG_W-1:0]         ser_len_q;
	logic [mwcs_pkg::CFG_W-1:0]         tot_cnt_q;
	logic [mwcs_pkg::SUM_W-1:0]         rank_sum_q;
	logic [POS_W-1:0]                   pos_q;
	logic                               out_valid_q;
	logic [mwcs_pkg::IDX_W-1:0]         split_index_q;
	logic [mwcs_pkg::STAT_W-1:0]        statistic_q;
	logic                               invalid_q;

	// Working registers of one transaction
	logic [mwcs_pkg::SUM_W-1:0]         r1_q;
	logic [mwcs_pkg::N_W-1:0]           n0_q;
	logic [mwcs_pkg::N_W-1:0]           n1_q;
	logic [mwcs_pkg::TC1_W-1:0]         tc1_q;
	logic [mwcs_pkg::IDX_W-1:0]         idx_q;
	logic                               inval_q;
	logic                               neg_q;
	logic [mwcs_pkg::MUL_W-1:0]         mag_q;
	logic [mwcs_pkg::MUL_W-2:0]         nn_q;
	logic [mwcs_pkg::M_W-1:0]           m_q;
	logic [mwcs_pkg::ROOT_W-1:0]        q_q;

	logic                               accept;
	logic [mwcs_pkg::CFG_W-1:0]         len;
	logic [mwcs_pkg::SUM_W-1:0]         r1;
	logic [mwcs_pkg::TC1_W-1:0]         pos_ext;
	logic [mwcs_pkg::TC1_W-1:0]         len_ext;
	logic                               produce;
	logic                               wrap;
	logic [mwcs_pkg::N_W-1:0]           n0;
	logic                               no_n1;
	logic                               out_free;

	logic [mwcs_pkg::MUL_W-1:0]         mul_a;
	logic [mwcs_pkg::MUL_W-1:0]         mul_b;
	logic [mwcs_pkg::PROD_W-1:0]        prod;
	logic [mwcs_pkg::D_W-1:0]           two_r1;
	logic [mwcs_pkg::D_W-1:0]           p_ext;
	logic [mwcs_pkg::D_W-1:0]           d_pos;
	logic [mwcs_pkg::D_W-1:0]           d_neg;
	logic [mwcs_pkg::M_W-1:0]           prod_w;
	logic [mwcs_pkg::M_W-1:0]           m12;
	logic                               sat;
	logic [mwcs_pkg::ROOT_W:0]          root_inc;
	logic [mwcs_pkg::STAT_W-1:0]        stat_val;

	mwcs_pkg::mwcs_ds_req_t             ds_req;
	mwcs_pkg::mwcs_ds_rsp_t             ds_rsp;

	// Decode the incoming transaction against the current position
	always_comb begin
		accept   = in_valid && in_ready;
		len      = (ser_len_q > LEN_CAP) ? LEN_CAP : ser_len_q;
		r1       = rank_sum_q + 24'(rank);
		pos_ext  = 14'(pos_q);
		len_ext  = {1'b0, len};
		produce  = (pos_ext != '0) && ((pos_ext + 14'd2) < len_ext);
		wrap     = (pos_ext + 14'd1) >= len_ext;
		n0       = 13'(pos_q) + 13'd1;
		no_n1    = tot_cnt_q <= n0;
		out_free = !out_valid_q || out_ready;
	end

	// Pick multiplier operands per step
	always_comb begin
		case (state_q)
			mwcs_pkg::ST_MUL1: begin
				mul_a = 27'(n0_q);
				mul_b = 27'(tc1_q);
			end
			mwcs_pkg::ST_MUL2: begin
				mul_a = 27'(n0_q);
				mul_b = 27'(n1_q);
			end
			mwcs_pkg::ST_MUL3: begin
				mul_a = mag_q;
				mul_b = mag_q;
			end
			mwcs_pkg::ST_MUL4: begin
				mul_a = {1'b0, nn_q};
				mul_b = 27'(tc1_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	mwcs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// Form D, 12*D^2, the saturation test and the final magnitude
	always_comb begin
		two_r1   = {3'b000, r1_q, 1'b0};
		p_ext    = {1'b0, prod[mwcs_pkg::MUL_W-1:0]};
		d_pos    = two_r1 - p_ext;
		d_neg    = p_ext - two_r1;
		prod_w   = {4'b0000, prod};
		m12      = (prod_w << 3) + (prod_w << 2);
		sat      = m_q >= {2'b00, prod[mwcs_pkg::V_W-1:0], 16'd0};
		root_inc = {1'b0, ds_rsp.root} + 25'd1;
		if (inval_q) begin
			stat_val = '0;
		end else if (neg_q) begin
			stat_val = 24'd0 - q_q;
		end else begin
			stat_val = (q_q > mwcs_pkg::SAT_POS) ? mwcs_pkg::SAT_POS : q_q;
		end
	end

	assign ds_req.start    = (state_q == mwcs_pkg::ST_SETUP) && !sat;
	assign ds_req.num_lo   = m_q[mwcs_pkg::DSH_W-1:0];
	assign ds_req.rem_init = m_q[mwcs_pkg::DSH_W +: mwcs_pkg::V_W];
	assign ds_req.den      = prod[mwcs_pkg::V_W-1:0];

	mwcs_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req),
		.rsp    (ds_rsp)
	);

	// Sequencer, running state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mwcs_pkg::ST_IDLE;
			ser_len_q   <= mwcs_pkg::CFG_RESET;
			tot_cnt_q   <= mwcs_pkg::CFG_RESET;
			rank_sum_q  <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == mwcs_pkg::REG_SERIES_LENGTH) begin
				ser_len_q <= cfg_data;
			end
			if (cfg_we && cfg_index == mwcs_pkg::REG_TOTAL_COUNT) begin
				tot_cnt_q <= cfg_data;
			end
			// Raise the output valid on a load, drop it once the result is taken
			if (state_q == mwcs_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				mwcs_pkg::ST_IDLE: begin
					if (accept) begin
						if (wrap) begin
							rank_sum_q <= '0;
							pos_q      <= '0;
						end else begin
							rank_sum_q <= r1;
							pos_q      <= pos_q + 1'b1;
						end
						if (produce) begin
							state_q <= no_n1 ? mwcs_pkg::ST_OUT : mwcs_pkg::ST_MUL1;
						end
					end
				end
				mwcs_pkg::ST_MUL1:  state_q <= mwcs_pkg::ST_MUL2;
				mwcs_pkg::ST_MUL2:  state_q <= mwcs_pkg::ST_MUL3;
				mwcs_pkg::ST_MUL3:  state_q <= mwcs_pkg::ST_MUL4;
				mwcs_pkg::ST_MUL4:  state_q <= mwcs_pkg::ST_SETUP;
				mwcs_pkg::ST_SETUP: begin
					state_q <= sat ? mwcs_pkg::ST_OUT : mwcs_pkg::ST_ROOT;
				end
				mwcs_pkg::ST_ROOT: begin
					if (ds_rsp.done) begin
						state_q <= mwcs_pkg::ST_OUT;
					end
				end
				mwcs_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= mwcs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mwcs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Capture operands and intermediate results, load the output payload
	always_ff @(posedge clk) begin
		case (state_q)
			mwcs_pkg::ST_IDLE: begin
				if (accept && produce) begin
					r1_q    <= r1;
					n0_q    <= n0;
					n1_q    <= tot_cnt_q - n0;
					tc1_q   <= {1'b0, tot_cnt_q} + 14'd1;
					idx_q   <= 12'(pos_q);
					inval_q <= no_n1;
				end
			end
			mwcs_pkg::ST_MUL2: begin
				neg_q <= d_pos[mwcs_pkg::D_W-1];
				mag_q <= d_pos[mwcs_pkg::D_W-1] ? d_neg[mwcs_pkg::MUL_W-1:0]
					: d_pos[mwcs_pkg::MUL_W-1:0];
			end
			mwcs_pkg::ST_MUL3: begin
				nn_q <= prod[mwcs_pkg::MUL_W-2:0];
			end
			mwcs_pkg::ST_MUL4: begin
				m_q <= m12;
			end
			mwcs_pkg::ST_SETUP: begin
				if (sat) begin
					q_q <= mwcs_pkg::MAG_CAP;
				end
			end
			mwcs_pkg::ST_ROOT: begin
				if (ds_rsp.done) begin
					q_q <= root_inc[mwcs_pkg::ROOT_W:1];
				end
			end
			mwcs_pkg::ST_OUT: begin
				if (out_free) begin
					split_index_q <= idx_q;
					statistic_q   <= stat_val;
					invalid_q     <= inval_q;
				end
			end
			default: begin
				q_q <= q_q;
			end
		endcase
	end

	assign in_ready    = (state_q == mwcs_pkg::ST_IDLE);
	assign out_valid   = out_valid_q;
	assign split_index = split_index_q;
	assign statistic   = $signed(statistic_q);
	assign invalid     = invalid_q;

endmodule

@@ design/mwcs_mul.sv @@
// Shared registered multiplier of the Mann-Whitney change-point scan.
module mwcs_mul (
	input  logic                         clk,
	input  logic [mwcs_pkg::MUL_W-1:0]   a,
	input  logic [mwcs_pkg::MUL_W-1:0]   b,
	output logic [mwcs_pkg::PROD_W-1:0]  p
);

	// Register the product
	always_ff @(posedge clk) begin
		p <= {{mwcs_pkg::MUL_W{1'b0}}, a} * {{mwcs_pkg::MUL_W{1'b0}}, b};
	end

endmodule

@@ design/mwcs_divsqrt.sv @@
// Restoring divider followed by restoring integer square root on one subtractor.
module mwcs_divsqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mwcs_pkg::mwcs_ds_req_t req,
	output mwcs_pkg::mwcs_ds_rsp_t rsp
);

	mwcs_pkg::mwcs_ds_phase_t       phase_q;
	logic [mwcs_pkg::CNT_W-1:0]     cnt_q;
	logic [mwcs_pkg::V_W-1:0]       rem_q;
	logic [mwcs_pkg::V_W-1:0]       den_q;
	logic [mwcs_pkg::DSH_W-1:0]     dsh_q;
	logic [mwcs_pkg::QUO_W-1:0]     wq_q;
	logic [mwcs_pkg::ROOT_W-1:0]    root_q;

	logic [mwcs_pkg::SUB_W-1:0]     sub_a;
	logic [mwcs_pkg::SUB_W-1:0]     sub_b;
	logic [mwcs_pkg::SUB_W:0]       diff;
	logic                           ge;

	// Select subtractor operands: remainder vs divisor, or remainder vs trial root
	always_comb begin
		case (phase_q)
			mwcs_pkg::DS_ROOT: begin
				sub_a = {13'd0, rem_q[mwcs_pkg::SQR_W-1:0],
					wq_q[mwcs_pkg::QUO_W-1 -: 2]};
				sub_b = {15'd0, root_q, 2'b01};
			end
			default: begin
				sub_a = {rem_q, dsh_q[mwcs_pkg::DSH_W-1]};
				sub_b = {1'b0, den_q};
			end
		endcase
		diff = {1'b0, sub_a} - {1'b0, sub_b};
		ge   = ~diff[mwcs_pkg::SUB_W];
	end

	assign rsp.done = (phase_q == mwcs_pkg::DS_ROOT) && (cnt_q == '0);
	assign rsp.root = {root_q[mwcs_pkg::ROOT_W-2:0], ge};

	// Sequence the phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mwcs_pkg::DS_IDLE;
			cnt_q   <= '0;
		end else begin
			case (phase_q)
				mwcs_pkg::DS_IDLE: begin
					if (req.start) begin
						phase_q <= mwcs_pkg::DS_DIV;
						cnt_q   <= 6'(mwcs_pkg::QUO_W - 1);
					end
				end
				mwcs_pkg::DS_DIV: begin
					if (cnt_q == '0) begin
						phase_q <= mwcs_pkg::DS_ROOT;
						cnt_q   <= 6'(mwcs_pkg::ROOT_W - 1);
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				mwcs_pkg::DS_ROOT: begin
					if (cnt_q == '0) begin
						phase_q <= mwcs_pkg::DS_IDLE;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				default: begin
					phase_q <= mwcs_pkg::DS_IDLE;
				end
			endcase
		end
	end

	// Advance remainder, quotient and root, one bit per cycle
	always_ff @(posedge clk) begin
		case (phase_q)
			mwcs_pkg::DS_IDLE: begin
				if (req.start) begin
					rem_q <= req.rem_init;
					den_q <= req.den;
					dsh_q <= req.num_lo;
				end
			end
			mwcs_pkg::DS_DIV: begin
				if (cnt_q == '0) begin
					// First root step starts from a cleared remainder
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					rem_q <= ge ? diff[mwcs_pkg::V_W-1:0] : sub_a[mwcs_pkg::V_W-1:0];
				end
				wq_q  <= {wq_q[mwcs_pkg::QUO_W-2:0], ge};
				dsh_q <= {dsh_q[mwcs_pkg::DSH_W-2:0], 1'b0};
			end
			mwcs_pkg::DS_ROOT: begin
				rem_q  <= ge ? 40'(diff[mwcs_pkg::SQR_W-1:0])
					: 40'(sub_a[mwcs_pkg::SQR_W-1:0]);
				root_q <= {root_q[mwcs_pkg::ROOT_W-2:0], ge};
				wq_q   <= {wq_q[mwcs_pkg::QUO_W-3:0], 2'b00};
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

endmodule

@@ tb/sv/mann_whitney_changepoint_scan_tb.sv @@
// Self-checking testbench of the Mann-Whitney change-point scan, with its own model of each split.
module mann_whitney_changepoint_scan_tb;

	localparam int RANK_W    = mwcs_pkg::RANK_W;
	localparam int CFG_W     = mwcs_pkg::CFG_W;
	localparam int REG_IDX_W = mwcs_pkg::REG_IDX_W;
	localparam int SUM_W     = mwcs_pkg::SUM_W;
	localparam int IDX_W     = mwcs_pkg::IDX_W;
	localparam int STAT_W    = mwcs_pkg::STAT_W;
	localparam int ROOT_W    = mwcs_pkg::ROOT_W;

	localparam int MAX_SERIES     = 4096;
	localparam int RANK_MAX       = (1 << RANK_W) - 1;
	localparam int CFG_MAX        = (1 << CFG_W) - 1;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 700;
	localparam int NEG_ITEMS      = 120;
	localparam int NEG_TOTAL      = 100;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 4'd9;

	typedef struct packed {
		logic [IDX_W-1:0]         split_index;
		logic signed [STAT_W-1:0] statistic;
		logic                     invalid;
	} split_result_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b1;
	logic                     cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data  = '0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic [RANK_W-1:0]        rank      = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [IDX_W-1:0]         split_index;
	logic signed [STAT_W-1:0] statistic;
	logic                     invalid;

	// Model copy of the registers and the running state
	logic [CFG_W-1:0] series_len_cfg  = mwcs_pkg::CFG_RESET;
	logic [CFG_W-1:0] total_count_cfg = mwcs_pkg::CFG_RESET;
	logic [SUM_W-1:0] rank_sum_acc    = '0;
	logic [IDX_W-1:0] split_pos       = '0;

	logic [RANK_W-1:0] pending_ranks[$];
	split_result_t     expected_splits[$];

	logic in_fired    = 1'b0;
	logic no_idle     = 1'b0;
	logic hold_armed  = 1'b0;
	logic hold_done   = 1'b0;
	int   hold_count  = 0;
	int   idle_cycles = 0;
	int   mismatch_count = 0;

	mann_whitney_changepoint_scan #(
		.MAX_LEN(MAX_SERIES)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rank       (rank),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.split_index(split_index),
		.statistic  (statistic),
		.invalid    (invalid)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Rounded |D|*sqrt(3/V)*2^16: largest q with (2q-1)^2 * V <= 12 * D^2 * 2^32
	function automatic logic [ROOT_W-1:0] stat_magnitude(input longint unsigned mag_d,
			input longint unsigned var_v);
		logic [127:0] target;
		logic [127:0] odd;
		logic [127:0] lhs;
		int unsigned  lo;
		int unsigned  hi;
		int unsigned  mid;
		target = (128'(mag_d) * 128'(mag_d) * 128'd12) << 32;
		lo = 0;
		hi = mwcs_pkg::MAG_CAP;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			odd = 128'(2 * mid - 1);
			lhs = odd * odd * 128'(var_v);
			if (lhs <= target) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return lo[ROOT_W-1:0];
	endfunction

	// Advance the model by one rank and queue the split it reports, if any
	function automatic void predict_split(input logic [RANK_W-1:0] r);
		int                len;
		longint            n0;
		longint            n1;
		longint            tc1;
		longint            d;
		logic [ROOT_W-1:0] q;
		logic [SUM_W-1:0]  r1;
		split_result_t     res;
		len = (series_len_cfg > MAX_SERIES) ? MAX_SERIES : int'(series_len_cfg);
		r1 = rank_sum_acc + SUM_W'(r);
		if (split_pos >= 1 && int'(split_pos) + 2 < len) begin
			n0 = longint'(split_pos) + 1;
			n1 = longint'(total_count_cfg) - n0;
			res.split_index = split_pos;
			res.statistic = '0;
			res.invalid = (n1 <= 0);
			if (n1 > 0) begin
				tc1 = longint'(total_count_cfg) + 1;
				d = 2 * longint'(r1) - n0 * tc1;
				q = stat_magnitude((d < 0) ? -d : d, n0 * n1 * tc1);
				if (d < 0) begin
					res.statistic = '0 - q;
				end else begin
					res.statistic = (q > mwcs_pkg::SAT_POS) ? mwcs_pkg::SAT_POS : q;
				end
			end
			expected_splits.push_back(res);
		end
		if (int'(split_pos) + 1 >= len) begin
			rank_sum_acc = '0;
			split_pos = '0;
		end else begin
			rank_sum_acc = r1;
			split_pos = split_pos + 1'b1;
		end
	endfunction

	// Sender: offer the next rank once the previous transaction is gone
	always @(negedge clk) begin
		if (!in_valid || in_fired) begin
			if (arst_n && pending_ranks.size() != 0
					&& (no_idle || $urandom_range(99) >= 33)) begin
				rank <= pending_ranks.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, one long hold-off when armed
	always @(negedge clk) begin
		if (hold_armed && !hold_done) begin
			out_ready <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_CYCLES - 1) begin
				hold_done <= 1'b1;
			end
		end else if (no_idle) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 33);
		end
	end

	// Monitor: predict on each input transaction, check each output transaction
	always @(posedge clk) begin
		split_result_t want;
		in_fired <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			predict_split(rank);
		end
		if (out_valid && out_ready) begin
			if (expected_splits.size() == 0) begin
				$error("unexpected result: split_index %0d statistic %0d invalid %0b",
					split_index, statistic, invalid);
				mismatch_count++;
			end else begin
				want = expected_splits.pop_front();
				if (split_index !== want.split_index) begin
					$error("split_index: expected %0d, actual %0d", want.split_index, split_index);
					mismatch_count++;
				end
				if (statistic !== want.statistic) begin
					$error("statistic: expected %0d, actual %0d", want.statistic, statistic);
					mismatch_count++;
				end
				if (invalid !== want.invalid) begin
					$error("invalid: expected %0b, actual %0b", want.invalid, invalid);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("mann_whitney_changepoint_scan regression: fail");
			$finish;
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == mwcs_pkg::REG_SERIES_LENGTH) begin
			series_len_cfg = value;
		end else if (idx == mwcs_pkg::REG_TOTAL_COUNT) begin
			total_count_cfg = value;
		end
	endtask

	// Wait until every rank is taken and every result has come, then let the block settle
	task automatic wait_idle();
		while (pending_ranks.size() != 0 || in_valid || expected_splits.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Queue a shuffled series 1..len, cut after keep ranks
	task automatic push_series(input int len, input int keep);
		int perm[$];
		int j;
		int tmp;
		for (int i = 1; i <= len; i++) begin
			perm.push_back(i);
		end
		for (int i = len - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		for (int i = 0; i < keep; i++) begin
			pending_ranks.push_back(RANK_W'(perm[i]));
		end
	endtask

	initial begin
		int random_count;
		int phase;
		int len;
		int total;
		int pick;
		int nseries;
		int count;

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: field extremes of the rank
		pending_ranks.push_back(RANK_W'(0));
		pending_ranks.push_back(RANK_W'(RANK_MAX));
		pending_ranks.push_back(RANK_W'(1));
		pending_ranks.push_back(RANK_W'(4096));
		wait_idle();

		// Second group empty: every split is flagged
		write_reg(mwcs_pkg::REG_SERIES_LENGTH, CFG_W'(4));
		write_reg(mwcs_pkg::REG_TOTAL_COUNT, CFG_W'(2));
		for (int i = 1; i <= 5; i++) begin
			pending_ranks.push_back(RANK_W'(i));
		end
		wait_idle();

		// Huge ranks against a tiny total: positive saturation; unused index is dropped
		write_reg(mwcs_pkg::REG_TOTAL_COUNT, CFG_W'(3));
		write_reg(mwcs_pkg::REG_SERIES_LENGTH, CFG_W'(5));
		write_reg(REG_UNUSED, CFG_W'(4));
		for (int i = 0; i < 5; i++) begin
			pending_ranks.push_back(RANK_W'(RANK_MAX));
		end
		wait_idle();

		// Short series give no result
		write_reg(mwcs_pkg::REG_SERIES_LENGTH, CFG_W'(3));
		for (int i = 0; i < 3; i++) begin
			pending_ranks.push_back(RANK_W'(i + 7));
		end
		wait_idle();
		write_reg(mwcs_pkg::REG_SERIES_LENGTH, CFG_W'(0));
		write_reg(mwcs_pkg::REG_TOTAL_COUNT, CFG_W'(0));
		pending_ranks.push_back(RANK_W'(5));
		pending_ranks.push_back(RANK_W'(RANK_MAX));
		wait_idle();
		write_reg(mwcs_pkg::REG_SERIES_LENGTH, CFG_W'(1));
		write_reg(mwcs_pkg::REG_TOTAL_COUNT, CFG_W'(CFG_MAX));
		pending_ranks.push_back(RANK_W'(2));
		pending_ranks.push_back(RANK_W'(3));
		wait_idle();
		write_reg(mwcs_pkg::REG_SERIES_LENGTH, CFG_W'(2));
		pending_ranks.push_back(RANK_W'(4));
		wait_idle();

		// Over-long series, tiny ranks: negative saturation, then empty second group
		write_reg(mwcs_pkg::REG_SERIES_LENGTH, CFG_W'(CFG_MAX));
		write_reg(mwcs_pkg::REG_TOTAL_COUNT, CFG_W'(NEG_TOTAL));
		for (int i = 0; i < NEG_ITEMS; i++) begin
			pending_ranks.push_back(RANK_W'($urandom_range(1)));
		end
		wait_idle();

		// Random phases: mostly whole shuffled series, some cut short, some noise
		random_count = 0;
		phase = 0;
		while (random_count < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				len = $urandom_range(3);
			end else if (pick < 15) begin
				len = $urandom_range(100, 160);
			end else begin
				len = $urandom_range(4, 24);
			end
			pick = $urandom_range(99);
			if (pick < 65) begin
				total = len;
			end else if (pick < 75) begin
				total = $urandom_range(len);
			end else if (pick < 85) begin
				total = CFG_MAX;
			end else if (pick < 95) begin
				total = $urandom_range(CFG_MAX);
			end else begin
				total = 2;
			end
			if (phase == 1) begin
				len = 120;
				total = 120;
			end
			if (phase == 3) begin
				len = 24;
				total = 24;
			end
			write_reg(mwcs_pkg::REG_SERIES_LENGTH, CFG_W'(len));
			write_reg(mwcs_pkg::REG_TOTAL_COUNT, CFG_W'(total));
			if ($urandom_range(9) == 0) begin
				write_reg(REG_UNUSED, CFG_W'($urandom_range(CFG_MAX)));
			end
			no_idle = (phase == 1);
			if (phase == 3) begin
				hold_armed = 1'b1;
			end

			count = pending_ranks.size();
			if (phase == 1 || phase == 3 || $urandom_range(99) < 80) begin
				nseries = (len > 24) ? 1 : $urandom_range(1, 3);
				if (phase == 3) begin
					nseries = 3;
				end
				for (int s = 0; s < nseries; s++) begin
					if (s == nseries - 1 && phase != 1 && $urandom_range(3) == 0) begin
						push_series((len < 2) ? 2 : len, $urandom_range(1, (len < 2) ? 2 : len));
					end else begin
						push_series((len < 2) ? 2 : len, (len < 2) ? 2 : len);
					end
				end
			end else begin
				for (int i = $urandom_range(1, 30); i > 0; i--) begin
					pending_ranks.push_back(RANK_W'($urandom_range(RANK_MAX)));
				end
			end
			random_count += pending_ranks.size() - count;
			wait_idle();
			no_idle = 1'b0;
			phase++;
		end

		wait_idle();
		if (mismatch_count == 0 && expected_splits.size() == 0) begin
			$display("mann_whitney_changepoint_scan regression: pass");
		end else begin
			$display("mann_whitney_changepoint_scan regression: fail");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/mwcs_pkg.sv
design/mwcs_mul.sv
design/mwcs_divsqrt.sv
design/mann_whitney_changepoint_scan.sv
tb/sv/mann_whitney_changepoint_scan_tb.sv
